FILE: rtl/ppgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection profile grid segmenter package
// Sizes, register indexes, result kinds and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package ppgs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_BANDS  = 32;

	localparam int W_C     = 10;
	localparam int W_WHITE = 8;
	localparam int W_CNT   = 6;
	localparam int W_KIND  = 2;
	localparam int W_CHAN  = 8;
	localparam int W_IDX   = 3;

	localparam int W_PX   = $clog2(MAX_WIDTH) + 1;
	localparam int W_PY   = $clog2(MAX_HEIGHT) + 1;
	localparam int W_MAXP = (W_PX > W_PY) ? W_PX : W_PY;
	localparam int W_SP   = ((W_MAXP > W_C + 1) ? W_MAXP : W_C + 1) + 1;

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int WALK_N = (MAX_WIDTH > (1 << W_C)) ? MAX_WIDTH : (1 << W_C);
	localparam int W_XW   = $clog2(WALK_N);
	localparam int W_WK   = W_XW + 1;

	localparam int W_S_DATA   = 3 * W_CHAN;
	localparam int W_OUT_BITS = 2 * W_C + 2 * W_CNT + 1;
	localparam int W_M_DATA   = ((W_OUT_BITS + 7) / 8) * 8;

	localparam logic [W_IDX-1:0] REG_LEFT   = 3'd0;
	localparam logic [W_IDX-1:0] REG_RIGHT  = 3'd1;
	localparam logic [W_IDX-1:0] REG_TOP    = 3'd2;
	localparam logic [W_IDX-1:0] REG_BOTTOM = 3'd3;
	localparam logic [W_IDX-1:0] REG_MX     = 3'd4;
	localparam logic [W_IDX-1:0] REG_MY     = 3'd5;
	localparam logic [W_IDX-1:0] REG_WHITE  = 3'd6;

	localparam logic [W_C-1:0]     RST_LEFT   = 10'd0;
	localparam logic [W_C-1:0]     RST_RIGHT  = 10'd1023;
	localparam logic [W_C-1:0]     RST_TOP    = 10'd0;
	localparam logic [W_C-1:0]     RST_BOTTOM = 10'd1023;
	localparam logic [W_C-1:0]     RST_MARGIN = 10'd15;
	localparam logic [W_WHITE-1:0] RST_WHITE  = 8'd200;

	localparam logic [W_KIND-1:0] KIND_ROW = 2'd0;
	localparam logic [W_KIND-1:0] KIND_COL = 2'd1;
	localparam logic [W_KIND-1:0] KIND_SUM = 2'd2;

	typedef struct packed {
		logic accept;
		logic clear_step;
		logic walk_step;
		logic cnt_reset;
		logic close_row;
		logic close_col;
		logic summary;
	} ppgs_cmd_t;

	typedef struct packed {
		logic out_free;
		logic depth_end;
		logic walk_end;
		logic walk_busy;
	} ppgs_sts_t;

endpackage

FILE: rtl/projection_profile_grid_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection profile grid segmenter
// Finds inked row and column bands of a grid region in an RGB raster frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while the output register is free; a result
// that is not yet taken holds off all pixel intake until it is taken. A row
// band is reported at the end of the row that closes it. At the last pixel of
// a frame the block stops taking pixels and walks the column flag memory, one
// column per clock through its single read port while the output register is
// free. Column bands follow in order, then a summary transaction with tlast
// set. After reset a clearing pass sets every column flag before the first
// pixel is taken; configuration writes are taken at any time and should be
// made while idle.
module projection_profile_grid_segmenter
	import ppgs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [W_IDX-1:0]    cfg_index,
	input  logic [W_C-1:0]      cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [W_S_DATA-1:0] s_tdata,   // red, green, blue
	input  logic                s_tuser,   // row_end
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [W_M_DATA-1:0] m_tdata,   // band_start, band_end, row_count,
	                                       // column_count, overflow
	output logic [W_KIND-1:0]   m_tuser,   // kind
	output logic                m_tlast
);

	ppgs_cmd_t cmd;
	ppgs_sts_t sts;

	ppgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppgs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/ppgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module ppgs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/ppgs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection profile grid segmenter controller
// Sequences the flag clearing pass, pixel intake and the frame-end steps.
// ----------------------------------------------------------------------------
module ppgs_ctrl
	import ppgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tlast,
	output logic       s_tready,
	input  ppgs_sts_t  sts,
	output ppgs_cmd_t  cmd
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_CLOSE = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_CLR: begin
				if (sts.depth_end) begin
					cmd.cnt_reset = 1'b1;
					state_d       = ST_RUN;
				end else begin
					cmd.clear_step = 1'b1;
				end
			end
			ST_RUN: begin
				s_tready   = sts.out_free;
				cmd.accept = s_tvalid && sts.out_free;
				if (cmd.accept && s_tlast) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (sts.out_free) begin
					cmd.close_row = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_end && !sts.walk_busy) begin
					cmd.cnt_reset = 1'b1;
					state_d       = ST_FIN;
				end else if (sts.out_free) begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.close_col = 1'b1;
					state_d       = ST_SUM;
				end
			end
			ST_SUM: begin
				if (sts.out_free) begin
					cmd.summary = 1'b1;
					state_d     = ST_RUN;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_cmd_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept || cmd.walk_step || cmd.close_row || cmd.close_col || cmd.summary)
		|-> sts.out_free)
		else $error("Command issued while the output register is blocked.");

	a_sum_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.summary |=> (state_q == ST_RUN))
		else $error("Summary did not return the controller to pixel intake.");

	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && sts.walk_end && !sts.walk_busy) |=> (state_q == ST_FIN))
		else $error("Column walk did not finish into the closing step.");
`endif

endmodule

FILE: rtl/ppgs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection profile grid segmenter datapath
// Configuration registers, row profile, column flag memory, band tracking
// and the output register.
// ----------------------------------------------------------------------------
module ppgs_dp
	import ppgs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [W_IDX-1:0]    cfg_index,
	input  logic [W_C-1:0]      cfg_data,
	input  logic [W_S_DATA-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [W_M_DATA-1:0] m_tdata,
	output logic [W_KIND-1:0]   m_tuser,
	output logic                m_tlast,
	input  ppgs_cmd_t           cmd,
	output ppgs_sts_t           sts
);

	logic [W_C-1:0]     left_q, right_q, top_q, bottom_q, mx_q, my_q;
	logic [W_WHITE-1:0] white_q;

	logic [W_PX-1:0] px_q;
	logic [W_PY-1:0] py_q;
	logic            row_aw_q;
	logic            in_band_q;
	logic [W_C-1:0]  band_start_q;
	logic [W_CNT-1:0] row_seen_q;
	logic            ovf_q;
	logic            open_q;
	logic [W_C-1:0]  col_start_q;
	logic [W_CNT-1:0] cols_q;

	logic [W_WK-1:0] cnt_q;
	logic            vld_s1;
	logic [W_XW-1:0] x_s1;
	logic            beyond_s1;

	logic             out_vld_q;
	logic [W_KIND-1:0] kind_q;
	logic [W_C-1:0]   start_q, end_q;
	logic [W_CNT-1:0] rc_q, cc_q;
	logic             ov_q, last_q;

	logic signed [W_SP-1:0] rlo, rhi, clo, chi, px_s, py_s, x_s, left_s, right_s;
	logic signed [W_SP-1:0] top_s, bottom_s;
	logic [W_CHAN-1:0] red, green, blue;
	logic white, in_img, hit_row, hit_col, row_span, col_span;
	logic row_end, row_valid, y_in, row_blank;
	logic row_open, row_close, close_forced, row_evt, rows_full, row_emit;
	logic [W_C-1:0] row_end_val;
	logic col_in, step_act, flag_s1, col_blank, col_open_evt, col_close_evt;
	logic cols_full, col_emit;
	logic [W_C-1:0] col_end_val;
	logic cnt_in_mem, cnt_in_walk, issue;
	logic ram_we, ram_wdata, ram_re, ram_rdata;
	logic [AW-1:0] ram_waddr;

	assign red   = s_tdata[W_CHAN-1:0];
	assign green = s_tdata[2*W_CHAN-1:W_CHAN];
	assign blue  = s_tdata[3*W_CHAN-1:2*W_CHAN];

	assign left_s   = $signed(W_SP'(left_q));
	assign right_s  = $signed(W_SP'(right_q));
	assign top_s    = $signed(W_SP'(top_q));
	assign bottom_s = $signed(W_SP'(bottom_q));
	assign rlo  = left_s + $signed(W_SP'(mx_q));
	assign rhi  = right_s - $signed(W_SP'(mx_q));
	assign clo  = top_s + $signed(W_SP'(my_q));
	assign chi  = bottom_s - $signed(W_SP'(my_q));
	assign px_s = $signed(W_SP'(px_q));
	assign py_s = $signed(W_SP'(py_q));
	assign x_s  = $signed(W_SP'(x_s1));

	assign row_span = rlo < rhi;
	assign col_span = clo < chi;

	assign white   = (red >= white_q) && (green >= white_q) && (blue >= white_q);
	assign in_img  = (px_q < W_PX'(MAX_WIDTH)) && (py_q < W_PY'(MAX_HEIGHT));
	assign hit_row = in_img && !white && (px_s >= rlo) && (px_s < rhi);
	assign hit_col = in_img && !white && (py_s >= clo) && (py_s < chi);

	// Row decision at the last pixel of a row.
	assign row_end      = s_tuser || s_tlast;
	assign row_valid    = py_q < W_PY'(MAX_HEIGHT);
	assign y_in         = (py_s > top_s) && (py_s < bottom_s);
	assign row_blank    = row_span && row_aw_q && !hit_row;
	assign row_open     = cmd.accept && row_end && row_valid && y_in && !row_blank
		&& !in_band_q;
	assign row_close    = cmd.accept && row_end && row_valid && y_in && row_blank
		&& in_band_q;
	assign close_forced = cmd.close_row && in_band_q;
	assign row_evt      = row_close || close_forced;
	assign rows_full    = row_seen_q >= W_CNT'(MAX_BANDS);
	assign row_emit     = row_evt && !rows_full;
	assign row_end_val  = row_close ? W_C'(py_q) : bottom_q;

	// Column decision for the flag read in the previous walk step.
	assign col_in        = (x_s > left_s) && (x_s < right_s);
	assign step_act      = cmd.walk_step && vld_s1 && col_in;
	assign flag_s1       = beyond_s1 || ram_rdata;
	assign col_blank     = col_span && flag_s1;
	assign col_open_evt  = step_act && !col_blank && !open_q;
	assign col_close_evt = (step_act && col_blank && open_q) || (cmd.close_col && open_q);
	assign cols_full     = cols_q >= W_CNT'(MAX_BANDS);
	assign col_emit      = col_close_evt && !cols_full;
	assign col_end_val   = cmd.close_col ? right_q : W_C'(x_s1);

	assign cnt_in_mem  = cnt_q < W_WK'(MAX_WIDTH);
	assign cnt_in_walk = cnt_q < W_WK'(WALK_N);
	assign issue       = cmd.walk_step && cnt_in_walk;

	always_comb begin
		if (cmd.accept) begin
			ram_we    = hit_col;
			ram_waddr = px_q[AW-1:0];
			ram_wdata = 1'b0;
		end else begin
			ram_we    = cmd.clear_step || (issue && cnt_in_mem);
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = 1'b1;
		end
	end
	assign ram_re = issue && cnt_in_mem;

	ppgs_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_col_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= RST_LEFT;
			right_q  <= RST_RIGHT;
			top_q    <= RST_TOP;
			bottom_q <= RST_BOTTOM;
			mx_q     <= RST_MARGIN;
			my_q     <= RST_MARGIN;
			white_q  <= RST_WHITE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_MX:     mx_q     <= cfg_data;
				REG_MY:     my_q     <= cfg_data;
				REG_WHITE:  white_q  <= cfg_data[W_WHITE-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q         <= '0;
			py_q         <= '0;
			row_aw_q     <= 1'b1;
			in_band_q    <= 1'b0;
			band_start_q <= '0;
			row_seen_q   <= '0;
			ovf_q        <= 1'b0;
			open_q       <= 1'b0;
			col_start_q  <= '0;
			cols_q       <= '0;
		end else begin
			if (cmd.accept) begin
				if (s_tlast) begin
					px_q     <= '0;
					py_q     <= '0;
					row_aw_q <= 1'b1;
				end else if (s_tuser) begin
					if (row_valid) begin
						py_q <= py_q + W_PY'(1);
					end
					px_q     <= '0;
					row_aw_q <= 1'b1;
				end else begin
					if (hit_row) begin
						row_aw_q <= 1'b0;
					end
					if (px_q < W_PX'(MAX_WIDTH)) begin
						px_q <= px_q + W_PX'(1);
					end
				end
			end
			if (row_open) begin
				in_band_q    <= 1'b1;
				band_start_q <= W_C'(py_q - W_PY'(1));
			end else if (row_evt) begin
				in_band_q <= 1'b0;
			end
			if (row_emit) begin
				row_seen_q <= row_seen_q + W_CNT'(1);
			end
			if (col_open_evt) begin
				open_q      <= 1'b1;
				col_start_q <= W_C'(x_s1 - W_XW'(1));
			end else if (col_close_evt) begin
				open_q <= 1'b0;
			end
			if (col_emit) begin
				cols_q <= cols_q + W_CNT'(1);
			end
			if ((row_evt && rows_full) || (col_close_evt && cols_full)) begin
				ovf_q <= 1'b1;
			end
			if (cmd.summary) begin
				in_band_q    <= 1'b0;
				band_start_q <= '0;
				row_seen_q   <= '0;
				ovf_q        <= 1'b0;
				open_q       <= 1'b0;
				col_start_q  <= '0;
				cols_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_reset) begin
				cnt_q <= '0;
			end else if (cmd.clear_step || issue) begin
				cnt_q <= cnt_q + W_WK'(1);
			end
			if (cmd.walk_step) begin
				vld_s1 <= cnt_in_walk;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1      <= cnt_q[W_XW-1:0];
			beyond_s1 <= !cnt_in_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (row_emit || col_emit || cmd.summary) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (row_emit) begin
			kind_q  <= KIND_ROW;
			start_q <= band_start_q;
			end_q   <= row_end_val;
			rc_q    <= '0;
			cc_q    <= '0;
			ov_q    <= 1'b0;
			last_q  <= 1'b0;
		end else if (col_emit) begin
			kind_q  <= KIND_COL;
			start_q <= col_start_q;
			end_q   <= col_end_val;
			rc_q    <= '0;
			cc_q    <= '0;
			ov_q    <= 1'b0;
			last_q  <= 1'b0;
		end else if (cmd.summary) begin
			kind_q  <= KIND_SUM;
			start_q <= '0;
			end_q   <= '0;
			rc_q    <= row_seen_q;
			cc_q    <= cols_q;
			ov_q    <= ovf_q;
			last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(W_M_DATA - W_OUT_BITS){1'b0}}, ov_q, cc_q, rc_q, end_q, start_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	assign sts.out_free  = !out_vld_q || m_tready;
	assign sts.depth_end = !cnt_in_mem;
	assign sts.walk_end  = !cnt_in_walk;
	assign sts.walk_busy = vld_s1;

`ifndef SYNTH
	a_row_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		row_seen_q <= W_CNT'(MAX_BANDS))
		else $error("Row band count passed its limit.");

	a_col_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cols_q <= W_CNT'(MAX_BANDS))
		else $error("Column band count passed its limit.");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && last_q) |-> (kind_q == KIND_SUM))
		else $error("Frame end marker on a result that is not the summary.");
`endif

endmodule
